// ===== rtl/text_console_draw_command_gen_defines.svh =====
// assertion macros for the text console draw command generator
`ifndef TEXT_CONSOLE_DRAW_COMMAND_GEN_DEFINES_SVH
`define TEXT_CONSOLE_DRAW_COMMAND_GEN_DEFINES_SVH

`ifndef SYNTH
// clocked check, quiet while reset is asserted
`define TCDC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds through reset
`define TCDC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCDC_ASSERT(label, clk, rst_n, prop, msg)
`define TCDC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/tcdc_pkg.sv =====
// shared types and constants of the text console draw command generator
package tcdc_pkg;

    // draw command opcodes
    typedef enum logic [1:0] {
        OP_FILL   = 2'd0,
        OP_GLYPH  = 2'd1,
        OP_SCROLL = 2'd2
    } t_op;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_ORIGIN_X   = 3'd0,
        REG_ORIGIN_Y   = 3'd1,
        REG_COLUMNS    = 3'd2,
        REG_ROWS       = 3'd3,
        REG_SCALE      = 3'd4,
        REG_TEXT_COLOR = 3'd5,
        REG_BACK_COLOR = 3'd6,
        REG_ENABLED    = 3'd7
    } t_reg_idx;

    // control character codes
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    // colors and register reset values
    localparam logic [23:0] BAR_COLOR       = 24'h6cc7ff;
    localparam logic [23:0] RST_TEXT_COLOR  = 24'h9defb0;
    localparam logic [23:0] RST_BACK_COLOR  = 24'h0b0e14;
    localparam logic [7:0]  RST_COLUMNS     = 8'd80;
    localparam logic [6:0]  RST_ROWS        = 7'd25;
    localparam logic [3:0]  RST_SCALE       = 4'd1;
    localparam logic [3:0]  MAX_SCALE       = 4'd8;

    // effective configuration, already clamped to legal values
    typedef struct packed {
        logic [12:0] origin_x;
        logic [12:0] origin_y;
        logic [7:0]  cols;
        logic [6:0]  rows;
        logic [3:0]  scale;
        logic [23:0] text_color;
        logic [23:0] back_color;
        logic        enabled;
    } t_cfg;

    // one draw command
    typedef struct packed {
        t_op         op;
        logic [13:0] pos_x;
        logic [13:0] pos_y;
        logic [13:0] span_w;
        logic [13:0] span_h;
        logic [23:0] paint;
        logic [23:0] ink;
        logic [7:0]  glyph;
        logic [7:0]  shift_px;
        logic [3:0]  glyph_scale;
    } t_cmd;

    // the commands caused by one input
    typedef t_cmd [3:0] t_cmd_list;

    // emitter status toward the input stage
    typedef struct packed {
        logic busy;
        logic free;
    } t_emit_stat;

endpackage

// ===== rtl/tcdc_regs.sv =====
// configuration register file with clamping of counts and scale
module tcdc_regs #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    output tcdc_pkg::t_cfg     o_cfg
);
    logic [12:0] r_origin_x;
    logic [12:0] r_origin_y;
    logic [7:0]  r_cols;
    logic [6:0]  r_rows;
    logic [3:0]  r_scale;
    logic [23:0] r_text_color;
    logic [23:0] r_back_color;
    logic        r_enabled;

    // register writes, one per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= '0;
            r_origin_y   <= '0;
            r_cols       <= tcdc_pkg::RST_COLUMNS;
            r_rows       <= tcdc_pkg::RST_ROWS;
            r_scale      <= tcdc_pkg::RST_SCALE;
            r_text_color <= tcdc_pkg::RST_TEXT_COLOR;
            r_back_color <= tcdc_pkg::RST_BACK_COLOR;
            r_enabled    <= 1'b0;
        end else if (i_cfg_valid) begin
            case (tcdc_pkg::t_reg_idx'(i_cfg_index))
                tcdc_pkg::REG_ORIGIN_X:   r_origin_x   <= i_cfg_data[12:0];
                tcdc_pkg::REG_ORIGIN_Y:   r_origin_y   <= i_cfg_data[12:0];
                tcdc_pkg::REG_COLUMNS:    r_cols       <= i_cfg_data[7:0];
                tcdc_pkg::REG_ROWS:       r_rows       <= i_cfg_data[6:0];
                tcdc_pkg::REG_SCALE:      r_scale      <= i_cfg_data[3:0];
                tcdc_pkg::REG_TEXT_COLOR: r_text_color <= i_cfg_data;
                tcdc_pkg::REG_BACK_COLOR: r_back_color <= i_cfg_data;
                tcdc_pkg::REG_ENABLED:    r_enabled    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp counts to 1..max and scale to 1..8
    always_comb begin
        o_cfg.origin_x   = r_origin_x;
        o_cfg.origin_y   = r_origin_y;
        o_cfg.text_color = r_text_color;
        o_cfg.back_color = r_back_color;
        o_cfg.enabled    = r_enabled;

        if (r_cols == 8'd0) begin
            o_cfg.cols = 8'd1;
        end else if (int'(r_cols) > MAX_COLUMNS) begin
            o_cfg.cols = 8'(MAX_COLUMNS);
        end else begin
            o_cfg.cols = r_cols;
        end

        if (r_rows == 7'd0) begin
            o_cfg.rows = 7'd1;
        end else if (int'(r_rows) > MAX_ROWS) begin
            o_cfg.rows = 7'(MAX_ROWS);
        end else begin
            o_cfg.rows = r_rows;
        end

        if (r_scale == 4'd0) begin
            o_cfg.scale = 4'd1;
        end else if (r_scale > tcdc_pkg::MAX_SCALE) begin
            o_cfg.scale = tcdc_pkg::MAX_SCALE;
        end else begin
            o_cfg.scale = r_scale;
        end
    end

endmodule

// ===== rtl/tcdc_step.sv =====
// cursor update and draw command list for one input
module tcdc_step (
    input  tcdc_pkg::t_cfg      i_cfg,
    input  logic [7:0]          i_col,
    input  logic [6:0]          i_row,
    input  logic                i_cmd,
    input  logic [7:0]          i_char_code,
    output tcdc_pkg::t_cmd_list o_cmds,
    output logic [2:0]          o_cnt,
    output logic [7:0]          o_col,
    output logic [6:0]          o_row
);
    // pixel offset of a column: col * 8 * s, modulo 2^14
    function automatic logic [13:0] col_px(input logic [7:0] col, input logic [3:0] s);
        logic [11:0] p;
        p = 12'(col) * 12'(s);
        return {p[10:0], 3'b000};
    endfunction

    // pixel offset of a row: row * 16 * s, modulo 2^14
    function automatic logic [13:0] row_px(input logic [6:0] row, input logic [3:0] s);
        logic [10:0] p;
        p = 11'(row) * 11'(s);
        return {p[9:0], 4'b0000};
    endfunction

    function automatic tcdc_pkg::t_cmd make_fill(
        input logic [13:0] x, input logic [13:0] y, input logic [13:0] w,
        input logic [13:0] h, input logic [23:0] color);
        tcdc_pkg::t_cmd c;
        c.op          = tcdc_pkg::OP_FILL;
        c.pos_x       = x;
        c.pos_y       = y;
        c.span_w      = w;
        c.span_h      = h;
        c.paint       = color;
        c.ink         = '0;
        c.glyph       = '0;
        c.shift_px    = '0;
        c.glyph_scale = 4'd1;
        return c;
    endfunction

    logic [13:0] w_ox;
    logic [13:0] w_oy;
    logic [13:0] w_cw;
    logic [13:0] w_bar_h;
    logic [13:0] w_bar_off;
    logic [7:0]  w_shift;
    logic [13:0] w_pan_w;
    logic [13:0] w_pan_h;
    logic [13:0] w_old_row_px;
    logic [7:0]  w_row_inc;
    logic        w_nl_scroll;
    logic [6:0]  w_nl_row;
    logic [8:0]  w_cols9;
    logic [8:0]  w_tab_sum;
    logic [8:0]  w_tab_t;
    logic [8:0]  w_inc_t;
    logic        w_is_bs;
    logic [7:0]  w_gcol;
    logic [7:0]  w_gchar;
    logic        w_glyph;
    logic        w_scroll;
    logic        w_newline;
    logic [7:0]  w_col;
    logic [6:0]  w_row;
    tcdc_pkg::t_cmd w_c_panel;
    tcdc_pkg::t_cmd w_c_erase;
    tcdc_pkg::t_cmd w_c_glyph;
    tcdc_pkg::t_cmd w_c_scroll;
    tcdc_pkg::t_cmd w_c_bar;

    // geometry from the scale
    assign w_ox         = 14'(i_cfg.origin_x);
    assign w_oy         = 14'(i_cfg.origin_y);
    assign w_cw         = 14'({i_cfg.scale, 3'b000});
    assign w_bar_h      = 14'({i_cfg.scale, 1'b0});
    assign w_bar_off    = 14'({i_cfg.scale, 4'b0000}) - w_bar_h;
    assign w_shift      = {i_cfg.scale, 4'b0000};
    assign w_pan_w      = col_px(i_cfg.cols, i_cfg.scale);
    assign w_pan_h      = row_px(i_cfg.rows, i_cfg.scale);
    assign w_old_row_px = row_px(i_row, i_cfg.scale);

    // candidate cursor moves
    assign w_row_inc   = {1'b0, i_row} + 8'd1;
    assign w_nl_scroll = (w_row_inc >= {1'b0, i_cfg.rows});
    assign w_nl_row    = w_nl_scroll ? (i_cfg.rows - 7'd1) : w_row_inc[6:0];
    assign w_cols9     = {1'b0, i_cfg.cols};
    assign w_tab_sum   = {1'b0, i_col} + 9'd4;
    assign w_tab_t     = {w_tab_sum[8:2], 2'b00};
    assign w_inc_t     = {1'b0, i_col} + 9'd1;
    assign w_is_bs     = (i_char_code == tcdc_pkg::CH_BS);
    assign w_gcol      = w_is_bs ? (i_col - 8'd1) : i_col;
    assign w_gchar     = w_is_bs ? tcdc_pkg::CH_SPACE : i_char_code;

    // next cursor and which middle commands appear
    always_comb begin
        w_col     = i_col;
        w_row     = i_row;
        w_glyph   = 1'b0;
        w_scroll  = 1'b0;
        w_newline = 1'b0;
        if (i_cmd) begin
            w_col = '0;
            w_row = '0;
        end else if (i_cfg.enabled) begin
            case (i_char_code)
                tcdc_pkg::CH_LF: begin
                    w_newline = 1'b1;
                end
                tcdc_pkg::CH_CR: begin
                    w_col = '0;
                end
                tcdc_pkg::CH_TAB: begin
                    if (w_tab_t >= w_cols9) begin
                        w_newline = 1'b1;
                    end else begin
                        w_col = w_tab_t[7:0];
                    end
                end
                tcdc_pkg::CH_BS: begin
                    if (i_col != 8'd0) begin
                        w_glyph = 1'b1;
                        w_col   = i_col - 8'd1;
                    end
                end
                default: begin
                    w_glyph = 1'b1;
                    if (w_inc_t >= w_cols9) begin
                        w_newline = 1'b1;
                    end else begin
                        w_col = w_inc_t[7:0];
                    end
                end
            endcase
            if (w_newline) begin
                w_col    = '0;
                w_row    = w_nl_row;
                w_scroll = w_nl_scroll;
            end
        end
    end

    // the individual commands
    always_comb begin
        w_c_panel = make_fill(w_ox, w_oy, w_pan_w, w_pan_h, i_cfg.back_color);
        w_c_erase = make_fill(w_ox + col_px(i_col, i_cfg.scale),
                              w_oy + w_old_row_px + w_bar_off,
                              w_cw, w_bar_h, i_cfg.back_color);
        w_c_bar   = make_fill(w_ox + col_px(w_col, i_cfg.scale),
                              w_oy + row_px(w_row, i_cfg.scale) + w_bar_off,
                              w_cw, w_bar_h, tcdc_pkg::BAR_COLOR);

        w_c_glyph             = make_fill(w_ox + col_px(w_gcol, i_cfg.scale),
                                          w_oy + w_old_row_px, '0, '0,
                                          i_cfg.back_color);
        w_c_glyph.op          = tcdc_pkg::OP_GLYPH;
        w_c_glyph.ink         = i_cfg.text_color;
        w_c_glyph.glyph       = w_gchar;
        w_c_glyph.glyph_scale = i_cfg.scale;

        w_c_scroll          = make_fill(w_ox, w_oy, w_pan_w, w_pan_h, i_cfg.back_color);
        w_c_scroll.op       = tcdc_pkg::OP_SCROLL;
        w_c_scroll.shift_px = w_shift;
    end

    // pack the list in emission order
    always_comb begin
        o_cmds[3] = w_c_bar;
        if (i_cmd) begin
            o_cmds[0] = w_c_panel;
            o_cmds[1] = w_c_bar;
            o_cmds[2] = w_c_bar;
            o_cnt     = 3'd2;
        end else begin
            o_cmds[0] = w_c_erase;
            if (w_glyph) begin
                o_cmds[1] = w_c_glyph;
                o_cmds[2] = w_scroll ? w_c_scroll : w_c_bar;
            end else begin
                o_cmds[1] = w_scroll ? w_c_scroll : w_c_bar;
                o_cmds[2] = w_c_bar;
            end
            o_cnt = i_cfg.enabled ? (3'd2 + 3'(w_glyph) + 3'(w_scroll)) : 3'd0;
        end
    end

    assign o_col = w_col;
    assign o_row = w_row;

endmodule

// ===== rtl/tcdc_emit.sv =====
// command list register and output sequencer, one command per cycle while the receiver is ready
module tcdc_emit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  tcdc_pkg::t_cmd_list    i_cmds,
    input  logic [2:0]             i_cnt,
    output tcdc_pkg::t_emit_stat   o_stat,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output tcdc_pkg::t_cmd         o_cmd,
    output logic                   o_last
);
    tcdc_pkg::t_cmd_list r_cmds;
    logic [2:0]          r_cnt;
    logic [1:0]          r_idx;
    logic                r_busy;
    logic                w_last;
    logic                w_done;

    assign w_last = (r_idx == 2'(r_cnt - 3'd1));
    assign w_done = r_busy && i_out_ready && w_last;

    // sequencing control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= (i_cnt != 3'd0);
            r_idx  <= '0;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end else if (r_busy && i_out_ready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    // command list payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cmds <= i_cmds;
            r_cnt  <= i_cnt;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.free = !r_busy || w_done;
    assign o_out_valid = r_busy;
    assign o_cmd       = r_cmds[r_idx];
    assign o_last      = w_last;

endmodule

// ===== rtl/text_console_draw_command_gen.sv =====
// top level of the text console draw command generator
// Usage:
//  Input channel (i_in_valid / o_in_ready) takes a command bit and a character byte:
//  command 0 puts a character, command 1 clears the panel. Each input yields zero to
//  four draw commands on the output channel (o_out_valid / i_out_ready), one per
//  transaction, with o_last set on the final one of the input.
//  Configuration writes use i_cfg_valid / o_cfg_ready with a register index and data;
//  o_cfg_ready is always high, and writes belong in idle periods.
//  The first command of an input passes through the input register and then the
//  command list register before it is presented. Throughput: one command per cycle
//  while the receiver is ready; an input gives up to four commands, and an input
//  that gives no command still passes through the command list register. The output
//  sequencer frees the list as its last command is taken.
//  An input register sits in front of the command list, so the next input is taken
//  while the current list is still being delivered.
//  When the receiver stalls, the current command holds and the input register fills,
//  then o_in_ready drops.
//  Reset clears the cursor to the top-left cell, drops all pending work and loads
//  the register defaults: 80 by 25 cells, scale 1, characters ignored.
`include "text_console_draw_command_gen_defines.svh"

module text_console_draw_command_gen #(
    parameter int MAX_COLUMNS = 128,
    parameter int MAX_ROWS    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_char_code,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_op,
    output logic [13:0] o_pos_x,
    output logic [13:0] o_pos_y,
    output logic [13:0] o_span_w,
    output logic [13:0] o_span_h,
    output logic [23:0] o_paint,
    output logic [23:0] o_ink,
    output logic [7:0]  o_glyph,
    output logic [7:0]  o_shift_px,
    output logic [3:0]  o_glyph_scale,
    output logic        o_last
);
    tcdc_pkg::t_cfg       w_cfg;
    tcdc_pkg::t_cmd_list  w_cmds;
    tcdc_pkg::t_cmd       w_cmd;
    tcdc_pkg::t_emit_stat w_stat;
    logic [2:0]           w_cnt;
    logic [7:0]           w_col;
    logic [6:0]           w_row;
    logic                 w_take;
    logic                 w_in_acc;

    logic                 r_in_vld;
    logic                 r_in_cmd;
    logic [7:0]           r_in_char;
    logic [7:0]           r_col;
    logic [6:0]           r_row;

    assign o_cfg_ready = 1'b1;

    tcdc_regs #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // input register handshake
    assign w_take     = r_in_vld && w_stat.free;
    assign o_in_ready = !r_in_vld || w_take;
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_take) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_cmd  <= i_cmd;
            r_in_char <= i_char_code;
        end
    end

    tcdc_step u_step (
        .i_cfg       (w_cfg),
        .i_col       (r_col),
        .i_row       (r_row),
        .i_cmd       (r_in_cmd),
        .i_char_code (r_in_char),
        .o_cmds      (w_cmds),
        .o_cnt       (w_cnt),
        .o_col       (w_col),
        .o_row       (w_row)
    );

    // cursor state advances when an input moves into the command list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_take) begin
            r_col <= w_col;
            r_row <= w_row;
        end
    end

    tcdc_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_take),
        .i_cmds      (w_cmds),
        .i_cnt       (w_cnt),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .o_last      (o_last)
    );

    // result fields
    assign o_op          = w_cmd.op;
    assign o_pos_x       = w_cmd.pos_x;
    assign o_pos_y       = w_cmd.pos_y;
    assign o_span_w      = w_cmd.span_w;
    assign o_span_h      = w_cmd.span_h;
    assign o_paint       = w_cmd.paint;
    assign o_ink         = w_cmd.ink;
    assign o_glyph       = w_cmd.glyph;
    assign o_shift_px    = w_cmd.shift_px;
    assign o_glyph_scale = w_cmd.glyph_scale;

    // checks
    `TCDC_ASSERT(a_clear_starts_fill, i_clk, i_rst_n, w_take && r_in_cmd |=> o_out_valid && o_op == tcdc_pkg::OP_FILL, "clear did not start with a panel fill")
    `TCDC_ASSERT(a_scroll_not_last, i_clk, i_rst_n, o_out_valid && o_op == tcdc_pkg::OP_SCROLL |-> !o_last, "scroll given as final command")
    `TCDC_ASSERT(a_non_glyph_fixed, i_clk, i_rst_n, o_out_valid && o_op != tcdc_pkg::OP_GLYPH |-> o_glyph_scale == 4'd1 && o_ink == 24'd0 && o_glyph == 8'd0, "glyph fields set on a non-glyph command")
    `TCDC_ASSERT(a_load_when_free, i_clk, i_rst_n, w_stat.busy && !i_out_ready |-> !w_take, "command list reloaded while stalled")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the text console draw command generator
module testbench;
    import tcdc_pkg::*;

    localparam int MAX_COLUMNS   = 128;
    localparam int MAX_ROWS      = 64;
    localparam int ITEM_TARGET   = 450;
    localparam int IDLE_PCT      = 21;
    localparam int SETTLE_CYCLES = 6;
    localparam int NO_TYPED      = -1;
    localparam int RUN_LIMIT_NS  = 5_000_000;

    // dut ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_cmd = 1'b0;
    logic [7:0]  i_char_code = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_op;
    logic [13:0] o_pos_x;
    logic [13:0] o_pos_y;
    logic [13:0] o_span_w;
    logic [13:0] o_span_h;
    logic [23:0] o_paint;
    logic [23:0] o_ink;
    logic [7:0]  o_glyph;
    logic [7:0]  o_shift_px;
    logic [3:0]  o_glyph_scale;
    logic        o_last;

    // one expected draw command and its end-of-input marker
    typedef struct {
        t_cmd cmd;
        logic last;
    } t_draw;

    // directed stimulus rows
    typedef enum {ROW_ITEM, ROW_CFG} t_row_kind;
    typedef struct {
        t_row_kind   kind;
        logic        clear;
        logic [7:0]  code;
        t_reg_idx    idx;
        logic [23:0] data;
        int          n_typed;
        t_cmd        first_typed;
    } t_row;

    t_draw pending_draws[$];
    t_draw draw_plan[$];
    t_row  directed_rows[$];
    int    errors = 0;
    bit    calm = 1'b0;

    // console state mirrored by the predictor
    logic [12:0] cfg_origin_x = '0;
    logic [12:0] cfg_origin_y = '0;
    logic [7:0]  cfg_cols = RST_COLUMNS;
    logic [6:0]  cfg_rows = RST_ROWS;
    logic [3:0]  cfg_scale = RST_SCALE;
    logic [23:0] cfg_text = RST_TEXT_COLOR;
    logic [23:0] cfg_back = RST_BACK_COLOR;
    logic        cfg_enabled = 1'b0;
    logic [7:0]  cur_col = '0;
    logic [6:0]  cur_row = '0;

    text_console_draw_command_gen #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS(MAX_ROWS)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_cmd(i_cmd),
        .i_char_code(i_char_code),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_op(o_op),
        .o_pos_x(o_pos_x),
        .o_pos_y(o_pos_y),
        .o_span_w(o_span_w),
        .o_span_h(o_span_h),
        .o_paint(o_paint),
        .o_ink(o_ink),
        .o_glyph(o_glyph),
        .o_shift_px(o_shift_px),
        .o_glyph_scale(o_glyph_scale),
        .o_last(o_last)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // clamped configuration
    function automatic int scale_now();
        if (cfg_scale == 0) return 1;
        if (cfg_scale > MAX_SCALE) return int'(MAX_SCALE);
        return int'(cfg_scale);
    endfunction

    function automatic int cols_now();
        if (cfg_cols == 0) return 1;
        if (cfg_cols > MAX_COLUMNS) return MAX_COLUMNS;
        return int'(cfg_cols);
    endfunction

    function automatic int rows_now();
        if (cfg_rows == 0) return 1;
        if (cfg_rows > MAX_ROWS) return MAX_ROWS;
        return int'(cfg_rows);
    endfunction

    // append one command to the plan, pixel values wrap at 14 bits
    function automatic void add_draw(t_op op, int x, int y, int w, int h,
                                     logic [23:0] paint, logic [23:0] ink,
                                     logic [7:0] gl, int shift, int gs);
        t_draw d;
        d.cmd             = '0;
        d.cmd.op          = op;
        d.cmd.pos_x       = x[13:0];
        d.cmd.pos_y       = y[13:0];
        d.cmd.span_w      = w[13:0];
        d.cmd.span_h      = h[13:0];
        d.cmd.paint       = paint;
        d.cmd.ink         = ink;
        d.cmd.glyph       = gl;
        d.cmd.shift_px    = shift[7:0];
        d.cmd.glyph_scale = gs[3:0];
        d.last            = 1'b0;
        draw_plan.push_back(d);
    endfunction

    // cursor bar: bottom 2*s lines of the cursor cell
    function automatic void cursor_bar(logic [23:0] color);
        int s;
        s = scale_now();
        add_draw(OP_FILL, cfg_origin_x + cur_col * 8 * s,
                 cfg_origin_y + cur_row * 16 * s + 14 * s, 8 * s, 2 * s,
                 color, '0, '0, 0, 1);
    endfunction

    // move to the next row, scrolling the panel past the last one
    function automatic void next_line();
        int s;
        int rows;
        int r;
        s    = scale_now();
        rows = rows_now();
        r    = cur_row + 1;
        cur_col = '0;
        if (r >= rows) begin
            add_draw(OP_SCROLL, cfg_origin_x, cfg_origin_y, cols_now() * 8 * s,
                     rows * 16 * s, cfg_back, '0, '0, 16 * s, 1);
            r = rows - 1;
        end
        cur_row = r[6:0];
    endfunction

    // predictor: draw commands caused by one input transaction
    function automatic void plan_draw_commands(logic clear, logic [7:0] code);
        int s;
        int t;
        s = scale_now();
        draw_plan.delete();
        if (clear) begin
            add_draw(OP_FILL, cfg_origin_x, cfg_origin_y, cols_now() * 8 * s,
                     rows_now() * 16 * s, cfg_back, '0, '0, 0, 1);
            cur_col = '0;
            cur_row = '0;
            cursor_bar(BAR_COLOR);
        end else if (cfg_enabled) begin
            cursor_bar(cfg_back);
            case (code)
                CH_LF: next_line();
                CH_CR: cur_col = '0;
                CH_TAB: begin
                    t = (cur_col + 4) & ~3;
                    if (t >= cols_now()) next_line();
                    else cur_col = t[7:0];
                end
                CH_BS: begin
                    // nothing to blank at the left edge
                    if (cur_col != 0) begin
                        cur_col = cur_col - 8'd1;
                        add_draw(OP_GLYPH, cfg_origin_x + cur_col * 8 * s,
                                 cfg_origin_y + cur_row * 16 * s, 0, 0,
                                 cfg_back, cfg_text, CH_SPACE, 0, s);
                    end
                end
                default: begin
                    add_draw(OP_GLYPH, cfg_origin_x + cur_col * 8 * s,
                             cfg_origin_y + cur_row * 16 * s, 0, 0,
                             cfg_back, cfg_text, code, 0, s);
                    t = cur_col + 1;
                    if (t >= cols_now()) next_line();
                    else cur_col = t[7:0];
                end
            endcase
            cursor_bar(BAR_COLOR);
        end
        if (draw_plan.size() != 0) draw_plan[draw_plan.size() - 1].last = 1'b1;
    endfunction

    function automatic t_cmd fill_cmd(int x, int y, int w, int h, logic [23:0] paint);
        t_cmd c;
        c             = '0;
        c.op          = OP_FILL;
        c.pos_x       = x[13:0];
        c.pos_y       = y[13:0];
        c.span_w      = w[13:0];
        c.span_h      = h[13:0];
        c.paint       = paint;
        c.glyph_scale = 4'd1;
        return c;
    endfunction

    function automatic void add_item(logic clear, logic [7:0] code, int n_typed,
                                     t_cmd first_typed);
        t_row r;
        r.kind        = ROW_ITEM;
        r.clear       = clear;
        r.code        = code;
        r.idx         = REG_ORIGIN_X;
        r.data        = '0;
        r.n_typed     = n_typed;
        r.first_typed = first_typed;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_cfg(t_reg_idx idx, logic [23:0] data);
        t_row r;
        r.kind        = ROW_CFG;
        r.clear       = 1'b0;
        r.code        = '0;
        r.idx         = idx;
        r.data        = data;
        r.n_typed     = NO_TYPED;
        r.first_typed = '0;
        directed_rows.push_back(r);
    endfunction

    // random register value, biased toward extremes and small panels
    function automatic logic [23:0] random_reg_value(t_reg_idx idx);
        case (idx)
            REG_ORIGIN_X, REG_ORIGIN_Y: begin
                case ($urandom_range(3))
                    0: return 24'd0;
                    1: return 24'd8191;
                    default: return 24'($urandom_range(8191));
                endcase
            end
            REG_COLUMNS: begin
                case ($urandom_range(9))
                    0: return 24'd0;
                    1: return 24'd128;
                    2: return 24'd255;
                    3, 4, 5: return 24'($urandom_range(255));
                    default: return 24'($urandom_range(1, 8));
                endcase
            end
            REG_ROWS: begin
                case ($urandom_range(9))
                    0: return 24'd0;
                    1: return 24'd64;
                    2: return 24'd127;
                    3, 4, 5: return 24'($urandom_range(127));
                    default: return 24'($urandom_range(1, 6));
                endcase
            end
            REG_SCALE: return 24'($urandom_range(15));
            REG_ENABLED: return 24'($urandom_range(9) != 0);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    // one input transaction, valid held until accepted
    task automatic send_input(input logic clear, input logic [7:0] code);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= clear;
        i_char_code <= code;
        do @(posedge i_clk); while (!o_in_ready);
        plan_draw_commands(clear, code);
        foreach (draw_plan[k]) pending_draws.push_back(draw_plan[k]);
        @(negedge i_clk);
    endtask

    // one register write transaction, after which valid is lowered before the task returns
    task automatic write_reg(input t_reg_idx idx, input logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_ORIGIN_X:   cfg_origin_x = data[12:0];
            REG_ORIGIN_Y:   cfg_origin_y = data[12:0];
            REG_COLUMNS:    cfg_cols     = data[7:0];
            REG_ROWS:       cfg_rows     = data[6:0];
            REG_SCALE:      cfg_scale    = data[3:0];
            REG_TEXT_COLOR: cfg_text     = data;
            REG_BACK_COLOR: cfg_back     = data;
            REG_ENABLED:    cfg_enabled  = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // wait for every expected command, then let a silent input finish
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (pending_draws.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // receiver stalls
    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // compare each draw command transaction with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_draw want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_draws.size() == 0) begin
                report_mismatch($sformatf("unexpected draw command op %0d", o_op));
            end else begin
                want = pending_draws.pop_front();
                check_field("op", 32'(o_op), 32'(want.cmd.op));
                check_field("pos_x", 32'(o_pos_x), 32'(want.cmd.pos_x));
                check_field("pos_y", 32'(o_pos_y), 32'(want.cmd.pos_y));
                check_field("span_w", 32'(o_span_w), 32'(want.cmd.span_w));
                check_field("span_h", 32'(o_span_h), 32'(want.cmd.span_h));
                check_field("paint", 32'(o_paint), 32'(want.cmd.paint));
                check_field("ink", 32'(o_ink), 32'(want.cmd.ink));
                check_field("glyph", 32'(o_glyph), 32'(want.cmd.glyph));
                check_field("shift_px", 32'(o_shift_px), 32'(want.cmd.shift_px));
                check_field("glyph_scale", 32'(o_glyph_scale),
                            32'(want.cmd.glyph_scale));
                check_field("last", 32'(o_last), 32'(want.last));
            end
        end
    end

    initial begin : stimulus
        t_row        row;
        t_reg_idx    idx;
        logic        clear;
        logic [7:0]  code;
        int          counted;
        int          pick;
        bit          last_was_item;

        counted       = 0;
        last_was_item = 1'b1;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // defaults: characters ignored, clear still acts
        add_item(1'b0, 8'h41, 0, '0);
        add_item(1'b1, 8'h00, 2, fill_cmd(0, 0, 640, 400, RST_BACK_COLOR));
        add_cfg(REG_ENABLED, 24'd1);
        add_item(1'b0, 8'h41, 3, fill_cmd(0, 14, 8, 2, RST_BACK_COLOR));
        // control codes, backspace at the left edge, byte extremes
        add_item(1'b0, CH_TAB, NO_TYPED, '0);
        add_item(1'b0, CH_CR, NO_TYPED, '0);
        add_item(1'b0, CH_BS, NO_TYPED, '0);
        add_item(1'b0, 8'hff, NO_TYPED, '0);
        add_item(1'b0, 8'h00, NO_TYPED, '0);
        add_item(1'b0, CH_BS, NO_TYPED, '0);
        add_item(1'b0, CH_LF, NO_TYPED, '0);
        // panel shrinks under the cursor row, one-cell panel wraps and scrolls
        add_cfg(REG_ROWS, 24'd1);
        add_cfg(REG_COLUMNS, 24'd1);
        add_item(1'b0, CH_LF, NO_TYPED, '0);
        add_item(1'b0, 8'h7a, NO_TYPED, '0);
        add_item(1'b0, CH_TAB, NO_TYPED, '0);
        // zero counts and scale act as one
        add_cfg(REG_COLUMNS, 24'd0);
        add_cfg(REG_ROWS, 24'd0);
        add_cfg(REG_SCALE, 24'd0);
        add_item(1'b0, 8'h78, NO_TYPED, '0);
        add_item(1'b0, CH_BS, NO_TYPED, '0);
        // oversized settings saturate, pixel math wraps
        add_cfg(REG_SCALE, 24'd15);
        add_cfg(REG_COLUMNS, 24'd255);
        add_cfg(REG_ROWS, 24'd127);
        add_cfg(REG_ORIGIN_X, 24'd8191);
        add_cfg(REG_ORIGIN_Y, 24'd8191);
        add_cfg(REG_TEXT_COLOR, 24'hffffff);
        add_cfg(REG_BACK_COLOR, 24'h000000);
        add_item(1'b1, 8'hff, 2, fill_cmd(8191, 8191, 8192, 8192, 24'h000000));
        add_item(1'b0, CH_LF, NO_TYPED, '0);
        add_item(1'b0, 8'h7e, NO_TYPED, '0);
        // cursor left beyond a narrowed panel
        add_cfg(REG_SCALE, 24'd1);
        add_cfg(REG_COLUMNS, 24'd128);
        add_cfg(REG_ROWS, 24'd64);
        add_cfg(REG_ORIGIN_X, 24'd0);
        add_cfg(REG_ORIGIN_Y, 24'd0);
        add_cfg(REG_BACK_COLOR, 24'h5a5a5a);
        add_item(1'b0, CH_TAB, NO_TYPED, '0);
        add_item(1'b0, CH_TAB, NO_TYPED, '0);
        add_item(1'b0, CH_TAB, NO_TYPED, '0);
        add_cfg(REG_COLUMNS, 24'd4);
        add_item(1'b0, 8'h61, NO_TYPED, '0);
        // disabled again
        add_cfg(REG_ENABLED, 24'd0);
        add_item(1'b0, 8'h62, 0, '0);
        add_item(1'b1, 8'h55, NO_TYPED, '0);
        add_cfg(REG_ENABLED, 24'd1);

        // directed part
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_CFG) begin
                if (last_was_item) drain_and_settle();
                write_reg(row.idx, row.data);
                last_was_item = 1'b0;
            end else begin
                send_input(row.clear, row.code);
                last_was_item = 1'b1;
                if (row.n_typed != NO_TYPED) begin
                    if (draw_plan.size() != row.n_typed)
                        report_mismatch($sformatf("row %0d: %0d commands planned, %0d typed",
                                                  k, draw_plan.size(), row.n_typed));
                    else if (row.n_typed > 0 && draw_plan[0].cmd != row.first_typed)
                        report_mismatch($sformatf("row %0d: first command differs from table",
                                                  k));
                end
            end
        end

        // random phases: a few register writes while idle, then a burst of inputs
        while (counted < ITEM_TARGET) begin
            drain_and_settle();
            repeat ($urandom_range(1, 4)) begin
                idx = t_reg_idx'($urandom_range(7));
                write_reg(idx, random_reg_value(idx));
            end
            repeat ($urandom_range(5, 25)) begin
                // one long stretch without idling on either side
                calm  = (counted >= 200 && counted < 280);
                pick  = $urandom_range(99);
                clear = (pick < 10);
                code  = 8'($urandom_range(255));
                if (pick >= 10 && pick < 50) begin
                    case ($urandom_range(3))
                        0: code = CH_LF;
                        1: code = CH_CR;
                        2: code = CH_TAB;
                        default: code = CH_BS;
                    endcase
                end
                send_input(clear, code);
                if (clear || cfg_enabled) counted++;
            end
        end
        calm = 1'b0;

        // end of run
        drain_and_settle();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
